### rtl/core/psd_pkg.sv
`timescale 1ns / 1ps
package psd_pkg;

  localparam int SECTION_ENTRIES = 4096;
  localparam int PALETTE_KEPT    = 256;
  localparam int PAL_AW          = $clog2(PALETTE_KEPT);

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  typedef enum logic [3:0] {
    PH_COUNT, PH_BPE, PH_SVAL, PH_SLEN, PH_SSKIP, PH_PLEN, PH_PENT, PH_DLEN,
    PH_WORDS, PH_BBPE, PH_BSVAL, PH_BPLEN, PH_BPENT, PH_BDLEN, PH_BSKIP, PH_HOLD
  } psd_phase_t;

  typedef enum logic [1:0] {
    ST_IN, ST_ENTRIES, ST_TAIL
  } psd_core_state_t;

  typedef enum logic [1:0] {
    U_IDLE, U_READ, U_SEND
  } psd_unpack_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] word;
    logic [5:0]  bits;
    logic [12:0] plen;
  } psd_unpack_cmd_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [31:0]       data;
  } psd_pal_wr_t;

  typedef struct packed {
    logic        valid;
    logic        busy;
    logic        last;
    logic [31:0] state;
  } psd_entry_t;

  // entries per 64-bit word at a given width
  function automatic logic [4:0] per_of(input logic [5:0] bits);
    logic [4:0] r;
    case (bits)
      6'd4: r = 5'd16;
      6'd5: r = 5'd12;
      6'd6: r = 5'd10;
      6'd7: r = 5'd9;
      6'd8: r = 5'd8;
      6'd9: r = 5'd7;
      6'd10: r = 5'd6;
      6'd11, 6'd12: r = 5'd5;
      6'd13, 6'd14, 6'd15, 6'd16: r = 5'd4;
      6'd17, 6'd18, 6'd19, 6'd20, 6'd21: r = 5'd3;
      default: r = 5'd2;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/psd_if.sv
`timescale 1ns / 1ps
interface psd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;
  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface psd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [11:0]        entry_index;
  logic signed [31:0] block_state;
  logic [12:0]        non_air_count;
  logic [35:0]        bytes_consumed;
  logic               run_last;
  modport source (output valid, kind, entry_index, block_state, non_air_count,
                  bytes_consumed, run_last, input ready);
  modport sink (input valid, kind, entry_index, block_state, non_air_count,
                bytes_consumed, run_last, output ready);
endinterface

### rtl/core/psd_unpack.sv
`timescale 1ns / 1ps
module psd_unpack (
  input  logic                      clk,
  input  logic                      rst_n,
  input  psd_pkg::psd_unpack_cmd_t  cmd,
  input  psd_pkg::psd_pal_wr_t      wr,
  input  logic [12:0]               next_entry,
  input  logic                      grant,
  output psd_pkg::psd_entry_t       ent
);

  logic [31:0] mem [psd_pkg::PALETTE_KEPT];
  logic [31:0] rdata_r;

  psd_pkg::psd_unpack_state_t st_r, st_nxt;
  logic [63:0] word_r, word_nxt;
  logic [5:0]  bits_r, bits_nxt;
  logic [12:0] plen_r, plen_nxt;
  logic [4:0]  ecnt_r, ecnt_nxt;
  logic [31:0] idx_r;
  logic        raw_r, hit_r;

  logic [4:0]  per;
  logic [31:0] mask;
  logic [31:0] idx;
  logic        more;

  assign per  = psd_pkg::per_of(bits_r);
  assign mask = 32'((33'd1 << bits_r) - 33'd1);
  assign idx  = word_r[31:0] & mask;
  assign more = (ecnt_r < per) && (next_entry < 13'(psd_pkg::SECTION_ENTRIES));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (st_r == psd_pkg::U_READ) begin
      rdata_r <= mem[idx[psd_pkg::PAL_AW-1:0]];
      idx_r   <= idx;
      raw_r   <= (plen_r == 13'd0);
      hit_r   <= (idx < {19'd0, plen_r}) && (idx < 32'(psd_pkg::PALETTE_KEPT));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= psd_pkg::U_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    word_r <= word_nxt;
    bits_r <= bits_nxt;
    plen_r <= plen_nxt;
    ecnt_r <= ecnt_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    word_nxt  = word_r;
    bits_nxt  = bits_r;
    plen_nxt  = plen_r;
    ecnt_nxt  = ecnt_r;
    ent.valid = 1'b0;
    ent.busy  = (st_r != psd_pkg::U_IDLE);
    ent.last  = (5'(ecnt_r + 5'd1) == per) ||
                (next_entry == 13'(psd_pkg::SECTION_ENTRIES - 1));
    ent.state = raw_r ? idx_r : (hit_r ? rdata_r : 32'd0);
    case (st_r)
      psd_pkg::U_IDLE: begin
        if (cmd.start) begin
          word_nxt = cmd.word;
          bits_nxt = cmd.bits;
          plen_nxt = cmd.plen;
          ecnt_nxt = 5'd0;
          st_nxt   = psd_pkg::U_READ;
        end
      end
      psd_pkg::U_READ: begin
        st_nxt = more ? psd_pkg::U_SEND : psd_pkg::U_IDLE;
      end
      psd_pkg::U_SEND: begin
        ent.valid = 1'b1;
        if (grant) begin
          word_nxt = word_r >> bits_r;
          ecnt_nxt = ecnt_r + 5'd1;
          st_nxt   = psd_pkg::U_READ;
        end
      end
      default: st_nxt = psd_pkg::U_IDLE;
    endcase
  end

endmodule

### rtl/core/paletted_section_decoder_core.sv
`timescale 1ns / 1ps
// channel   dir  payload                                                     done when
// in_chan   in   data_byte, end_of_buffer                                    valid & ready
// out_chan  out  kind, entry_index, block_state, non_air_count,              valid & ready
//                bytes_consumed, run_last
//
// a byte that causes no result leaves the sequencer in the byte state; a byte that
// causes only a fill, done or error moves it to the tail state, which emits each result in turn
// the byte closing a packed word runs the shared unpack unit: per entry an index
// extract and registered palette read, then an output offer; up to 16 entries per word
// synchronous active-low reset returns to waiting for the count field; the
// palette memory is not cleared
// a stalled output holds the sequencer; input is taken only in the byte state
module paletted_section_decoder_core (
  input  logic      clk,
  input  logic      rst_n,
  psd_in_if.sink    in_chan,
  psd_out_if.source out_chan
);

  // parser state
  psd_pkg::psd_phase_t phase_r, phase_nxt;
  logic [31:0] vint_r, vint_nxt;
  logic [2:0]  vshift_r, vshift_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [5:0]  ebits_r, ebits_nxt;
  logic [12:0] plen_r, plen_nxt;
  logic [12:0] pri_r, pri_nxt;
  logic [30:0] words_r, words_nxt;
  logic [63:0] word_r, word_nxt;
  logic [12:0] ne_r, ne_nxt;
  logic [12:0] tally_r, tally_nxt;
  logic [34:0] skip_r, skip_nxt;
  logic [35:0] bytes_r, bytes_nxt;
  logic        clr_pend_r, clr_pend_nxt;

  // sequencer and pending tail results
  psd_pkg::psd_core_state_t st_r, st_nxt;
  logic        tfill_r, tfill_nxt;
  logic        tend_r, tend_nxt;
  logic [1:0]  tkind_r, tkind_nxt;
  logic [11:0] fstart_r, fstart_nxt;
  logic [31:0] fval_r, fval_nxt;
  logic [12:0] dnon_r, dnon_nxt;
  logic [35:0] dbytes_r, dbytes_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [11:0] oidx_r, oidx_nxt;
  logic [31:0] ostate_r, ostate_nxt;
  logic [12:0] onon_r, onon_nxt;
  logic [35:0] obytes_r, obytes_nxt;
  logic        olast_r, olast_nxt;

  psd_pkg::psd_unpack_cmd_t cmd;
  psd_pkg::psd_pal_wr_t     wr;
  psd_pkg::psd_entry_t      ent;
  logic                     grant;

  logic        accept, out_free;
  logic [7:0]  b;
  logic        eob;
  logic [4:0]  vsh;
  logic [31:0] vnew;
  logic        vdone, vlong;
  logic        err, done, fill, sec_clr;
  logic [11:0] fill_start;
  logic [31:0] fill_val;
  logic [63:0] word_full;
  logic [5:0]  bits_c;
  logic [13:0] ne_end;

  assign accept          = in_chan.valid && in_chan.ready;
  assign in_chan.ready   = (st_r == psd_pkg::ST_IN);
  assign out_free        = !ov_r || out_chan.ready;
  assign b               = in_chan.data_byte;
  assign eob             = in_chan.end_of_buffer;

  assign out_chan.valid          = ov_r;
  assign out_chan.kind           = okind_r;
  assign out_chan.entry_index    = oidx_r;
  assign out_chan.block_state    = ostate_r;
  assign out_chan.non_air_count  = onon_r;
  assign out_chan.bytes_consumed = obytes_r;
  assign out_chan.run_last       = olast_r;

  // varint accumulate, 7 bits per byte, fifth byte truncated by the 32-bit width
  always_comb begin
    case (vshift_r)
      3'd0: vsh = 5'd0;
      3'd1: vsh = 5'd7;
      3'd2: vsh = 5'd14;
      3'd3: vsh = 5'd21;
      default: vsh = 5'd28;
    endcase
  end
  assign vnew  = vint_r | ({25'd0, b[6:0]} << vsh);
  assign vdone = !b[7];
  assign vlong = b[7] && (vshift_r >= 3'd4);

  assign word_full = {word_r[55:0], b};
  assign bits_c    = (ebits_r < 6'd4) ? 6'd4 : ((ebits_r > 6'd32) ? 6'd32 : ebits_r);

  // where the entry run of this word will stop
  always_comb begin
    logic [13:0] sum;
    sum = {1'b0, ne_r} + {9'd0, psd_pkg::per_of(bits_c)};
    if (ne_r >= 13'(psd_pkg::SECTION_ENTRIES)) begin
      ne_end = {1'b0, ne_r};
    end else if (sum > 14'(psd_pkg::SECTION_ENTRIES)) begin
      ne_end = 14'(psd_pkg::SECTION_ENTRIES);
    end else begin
      ne_end = sum;
    end
  end

  psd_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .wr         (wr),
    .next_entry (ne_r),
    .grant      (grant),
    .ent        (ent)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= psd_pkg::PH_COUNT;
      vint_r     <= '0;
      vshift_r   <= '0;
      fcnt_r     <= '0;
      ebits_r    <= '0;
      plen_r     <= '0;
      pri_r      <= '0;
      words_r    <= '0;
      word_r     <= '0;
      ne_r       <= '0;
      tally_r    <= '0;
      skip_r     <= '0;
      bytes_r    <= '0;
      clr_pend_r <= 1'b0;
      st_r       <= psd_pkg::ST_IN;
      tfill_r    <= 1'b0;
      tend_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      vint_r     <= vint_nxt;
      vshift_r   <= vshift_nxt;
      fcnt_r     <= fcnt_nxt;
      ebits_r    <= ebits_nxt;
      plen_r     <= plen_nxt;
      pri_r      <= pri_nxt;
      words_r    <= words_nxt;
      word_r     <= word_nxt;
      ne_r       <= ne_nxt;
      tally_r    <= tally_nxt;
      skip_r     <= skip_nxt;
      bytes_r    <= bytes_nxt;
      clr_pend_r <= clr_pend_nxt;
      st_r       <= st_nxt;
      tfill_r    <= tfill_nxt;
      tend_r     <= tend_nxt;
      ov_r       <= ov_nxt;
    end
    tkind_r  <= tkind_nxt;
    fstart_r <= fstart_nxt;
    fval_r   <= fval_nxt;
    dnon_r   <= dnon_nxt;
    dbytes_r <= dbytes_nxt;
    okind_r  <= okind_nxt;
    oidx_r   <= oidx_nxt;
    ostate_r <= ostate_nxt;
    onon_r   <= onon_nxt;
    obytes_r <= obytes_nxt;
    olast_r  <= olast_nxt;
  end

  always_comb begin
    phase_nxt    = phase_r;
    vint_nxt     = vint_r;
    vshift_nxt   = vshift_r;
    fcnt_nxt     = fcnt_r;
    ebits_nxt    = ebits_r;
    plen_nxt     = plen_r;
    pri_nxt      = pri_r;
    words_nxt    = words_r;
    word_nxt     = word_r;
    ne_nxt       = ne_r;
    tally_nxt    = tally_r;
    skip_nxt     = skip_r;
    bytes_nxt    = bytes_r;
    clr_pend_nxt = clr_pend_r;
    st_nxt       = st_r;
    tfill_nxt    = tfill_r;
    tend_nxt     = tend_r;
    tkind_nxt    = tkind_r;
    fstart_nxt   = fstart_r;
    fval_nxt     = fval_r;
    dnon_nxt     = dnon_r;
    dbytes_nxt   = dbytes_r;
    ov_nxt       = ov_r && !out_chan.ready;
    okind_nxt    = okind_r;
    oidx_nxt     = oidx_r;
    ostate_nxt   = ostate_r;
    onon_nxt     = onon_r;
    obytes_nxt   = obytes_r;
    olast_nxt    = olast_r;
    err          = 1'b0;
    done         = 1'b0;
    fill         = 1'b0;
    sec_clr      = 1'b0;
    fill_start   = 12'd0;
    fill_val     = 32'd0;
    cmd          = '0;
    wr           = '0;
    grant        = 1'b0;

    case (st_r)
      psd_pkg::ST_IN: begin
        if (accept && phase_r == psd_pkg::PH_HOLD) begin
          // swallow bytes after an error up to the end of the buffer
          if (eob) begin
            sec_clr = 1'b1;
          end
        end else if (accept) begin
          bytes_nxt = bytes_r + 36'd1;

          // varint phases share one accumulator
          if (phase_r == psd_pkg::PH_SVAL  || phase_r == psd_pkg::PH_SLEN  ||
              phase_r == psd_pkg::PH_PLEN  || phase_r == psd_pkg::PH_PENT  ||
              phase_r == psd_pkg::PH_DLEN  || phase_r == psd_pkg::PH_BSVAL ||
              phase_r == psd_pkg::PH_BPLEN || phase_r == psd_pkg::PH_BPENT ||
              phase_r == psd_pkg::PH_BDLEN) begin
            if (vdone || vlong) begin
              vint_nxt   = 32'd0;
              vshift_nxt = 3'd0;
            end else begin
              vint_nxt   = vnew;
              vshift_nxt = vshift_r + 3'd1;
            end
          end

          case (phase_r)
            psd_pkg::PH_COUNT: begin
              fcnt_nxt = fcnt_r + 3'd1;
              if (fcnt_r >= 3'd1) begin
                fcnt_nxt  = 3'd0;
                phase_nxt = psd_pkg::PH_BPE;
              end
            end
            psd_pkg::PH_BPE: begin
              ebits_nxt = (b < 8'd4) ? 6'd4 : b[5:0];
              if (b == 8'd0) phase_nxt = psd_pkg::PH_SVAL;
              else if (b > 8'd32) err = 1'b1;
              else if (b <= 8'd8) phase_nxt = psd_pkg::PH_PLEN;
              else phase_nxt = psd_pkg::PH_DLEN;
            end
            psd_pkg::PH_SVAL: begin
              if (vlong) err = 1'b1;
              else if (vdone) begin
                word_nxt  = {32'd0, vnew};
                phase_nxt = psd_pkg::PH_SLEN;
              end
            end
            psd_pkg::PH_SLEN: begin
              if (vlong || (vdone && vnew[31])) err = 1'b1;
              else if (vdone) begin
                // single value covers the whole section
                fill      = 1'b1;
                fill_val  = word_r[31:0];
                tally_nxt = (word_r[31:0] != 32'd0) ?
                            13'(psd_pkg::SECTION_ENTRIES) : 13'd0;
                skip_nxt  = {vnew[31:0], 3'd0};
                phase_nxt = (vnew != 32'd0) ? psd_pkg::PH_SSKIP : psd_pkg::PH_BBPE;
              end
            end
            psd_pkg::PH_SSKIP, psd_pkg::PH_BSKIP: begin
              if (skip_r != 35'd0) skip_nxt = skip_r - 35'd1;
              if (skip_r <= 35'd1) begin
                if (phase_r == psd_pkg::PH_SSKIP) phase_nxt = psd_pkg::PH_BBPE;
                else done = 1'b1;
              end
            end
            psd_pkg::PH_PLEN: begin
              if (vlong || (vdone && vnew > 32'(psd_pkg::SECTION_ENTRIES))) err = 1'b1;
              else if (vdone) begin
                plen_nxt  = vnew[12:0];
                pri_nxt   = 13'd0;
                phase_nxt = (vnew != 32'd0) ? psd_pkg::PH_PENT : psd_pkg::PH_DLEN;
              end
            end
            psd_pkg::PH_PENT: begin
              if (vlong) err = 1'b1;
              else if (vdone) begin
                wr.en   = (pri_r < 13'(psd_pkg::PALETTE_KEPT));
                wr.addr = pri_r[psd_pkg::PAL_AW-1:0];
                wr.data = vnew;
                pri_nxt = pri_r + 13'd1;
                if (pri_r + 13'd1 >= plen_r) phase_nxt = psd_pkg::PH_DLEN;
              end
            end
            psd_pkg::PH_DLEN: begin
              if (vlong || (vdone && vnew[31])) err = 1'b1;
              else if (vdone) begin
                ne_nxt    = 13'd0;
                tally_nxt = 13'd0;
                fcnt_nxt  = 3'd0;
                word_nxt  = 64'd0;
                words_nxt = vnew[30:0];
                if (vnew == 32'd0) begin
                  fill      = 1'b1;
                  phase_nxt = psd_pkg::PH_BBPE;
                end else begin
                  phase_nxt = psd_pkg::PH_WORDS;
                end
              end
            end
            psd_pkg::PH_WORDS: begin
              word_nxt = word_full;
              fcnt_nxt = fcnt_r + 3'd1;
              if (fcnt_r == 3'd7) begin
                // hand the word to the unpack unit
                cmd.start = 1'b1;
                cmd.word  = word_full;
                cmd.bits  = bits_c;
                cmd.plen  = plen_r;
                fcnt_nxt  = 3'd0;
                word_nxt  = 64'd0;
                if (words_r != 31'd0) words_nxt = words_r - 31'd1;
                if (words_r <= 31'd1) begin
                  if (ne_end < 14'(psd_pkg::SECTION_ENTRIES)) begin
                    fill       = 1'b1;
                    fill_start = ne_end[11:0];
                  end
                  phase_nxt = psd_pkg::PH_BBPE;
                end
              end
            end
            psd_pkg::PH_BBPE: begin
              if (b == 8'd0) phase_nxt = psd_pkg::PH_BSVAL;
              else if (b <= 8'd3) phase_nxt = psd_pkg::PH_BPLEN;
              else phase_nxt = psd_pkg::PH_BDLEN;
            end
            psd_pkg::PH_BSVAL: begin
              if (vlong) err = 1'b1;
              else if (vdone) phase_nxt = psd_pkg::PH_BDLEN;
            end
            psd_pkg::PH_BPLEN: begin
              if (vlong) err = 1'b1;
              else if (vdone) begin
                words_nxt = vnew[31] ? 31'd0 : vnew[30:0];
                phase_nxt = (!vnew[31] && vnew[30:0] != 31'd0) ?
                            psd_pkg::PH_BPENT : psd_pkg::PH_BDLEN;
              end
            end
            psd_pkg::PH_BPENT: begin
              if (vlong) err = 1'b1;
              else if (vdone) begin
                if (words_r != 31'd0) words_nxt = words_r - 31'd1;
                if (words_r <= 31'd1) phase_nxt = psd_pkg::PH_BDLEN;
              end
            end
            psd_pkg::PH_BDLEN: begin
              if (vlong || (vdone && vnew[31])) err = 1'b1;
              else if (vdone) begin
                skip_nxt = {vnew[31:0], 3'd0};
                if (vnew != 32'd0) phase_nxt = psd_pkg::PH_BSKIP;
                else done = 1'b1;
              end
            end
            default: sec_clr = 1'b1;
          endcase

          // end of buffer inside a section is malformed
          if (!done && eob) err = 1'b1;

          tfill_nxt  = fill && !err;
          fstart_nxt = fill_start;
          fval_nxt   = fill_val;
          tend_nxt   = err || done;
          tkind_nxt  = err ? psd_pkg::KIND_ERROR : psd_pkg::KIND_DONE;
          dnon_nxt   = tally_r;
          dbytes_nxt = bytes_r + 36'd1;
          if (err) begin
            if (eob) sec_clr = 1'b1;
            else phase_nxt = psd_pkg::PH_HOLD;
          end else if (done) begin
            sec_clr = 1'b1;
          end

          if (cmd.start) st_nxt = psd_pkg::ST_ENTRIES;
          else if ((fill && !err) || err || done) st_nxt = psd_pkg::ST_TAIL;
        end

        if (sec_clr) begin
          phase_nxt  = psd_pkg::PH_COUNT;
          vint_nxt   = 32'd0;
          vshift_nxt = 3'd0;
          fcnt_nxt   = 3'd0;
          ebits_nxt  = 6'd0;
          plen_nxt   = 13'd0;
          pri_nxt    = 13'd0;
          words_nxt  = 31'd0;
          word_nxt   = 64'd0;
          skip_nxt   = 35'd0;
          bytes_nxt  = 36'd0;
          // entry counters still drive an unpack run; clear them afterwards
          if (cmd.start) begin
            clr_pend_nxt = 1'b1;
          end else begin
            ne_nxt    = 13'd0;
            tally_nxt = 13'd0;
          end
        end
      end

      psd_pkg::ST_ENTRIES: begin
        if (ent.valid && out_free) begin
          grant      = 1'b1;
          ov_nxt     = 1'b1;
          okind_nxt  = psd_pkg::KIND_ENTRY;
          oidx_nxt   = ne_r[11:0];
          ostate_nxt = ent.state;
          onon_nxt   = 13'd0;
          obytes_nxt = 36'd0;
          olast_nxt  = ent.last && !tfill_r && !tend_r;
          ne_nxt     = ne_r + 13'd1;
          if (ent.state != 32'd0) tally_nxt = tally_r + 13'd1;
        end else if (!ent.busy) begin
          if (tfill_r || tend_r) begin
            st_nxt = psd_pkg::ST_TAIL;
          end else begin
            st_nxt = psd_pkg::ST_IN;
            if (clr_pend_r) begin
              ne_nxt       = 13'd0;
              tally_nxt    = 13'd0;
              clr_pend_nxt = 1'b0;
            end
          end
        end
      end

      psd_pkg::ST_TAIL: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          ostate_nxt = 32'd0;
          oidx_nxt   = 12'd0;
          onon_nxt   = 13'd0;
          obytes_nxt = 36'd0;
          if (tfill_r) begin
            okind_nxt  = psd_pkg::KIND_FILL;
            oidx_nxt   = fstart_r;
            ostate_nxt = fval_r;
            olast_nxt  = !tend_r;
            tfill_nxt  = 1'b0;
          end else begin
            okind_nxt = tkind_r;
            olast_nxt = 1'b1;
            tend_nxt  = 1'b0;
            if (tkind_r == psd_pkg::KIND_DONE) begin
              onon_nxt   = dnon_r;
              obytes_nxt = dbytes_r;
            end
          end
          if (!tfill_r || !tend_r) begin
            st_nxt = psd_pkg::ST_IN;
            if (clr_pend_r) begin
              ne_nxt       = 13'd0;
              tally_nxt    = 13'd0;
              clr_pend_nxt = 1'b0;
            end
          end
        end
      end

      default: st_nxt = psd_pkg::ST_IN;
    endcase
  end

  // unpack unit runs only while the sequencer waits on it
  a_unpack_owned: assert property (@(posedge clk) disable iff (!rst_n)
    ent.busy |-> st_r == psd_pkg::ST_ENTRIES)
    else $error("unpack busy outside entry state");

  // entry position never passes the section size
  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ne_r <= 13'(psd_pkg::SECTION_ENTRIES))
    else $error("entry position past section end");

  // no tail result left behind when a new byte may be taken
  a_tail_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == psd_pkg::ST_IN |-> !tfill_r && !tend_r)
    else $error("pending tail result in byte state");

  // a granted entry lands in the output register
  a_grant_loads: assert property (@(posedge clk) disable iff (!rst_n)
    grant |=> ov_r && okind_r == psd_pkg::KIND_ENTRY)
    else $error("granted entry not loaded");

endmodule
